// ===== src/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, constants and codes for the NTC thermistor converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_pkg;

    // default converter resolution
    localparam int AdcBitsDef = 12;

    // configuration port
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 16;
    localparam logic [CfgAddrW-1:0] RegBeta = 2'd0;
    localparam logic [CfgAddrW-1:0] RegT0   = 2'd1;

    localparam int BetaW = 14;
    localparam int T0W   = 16;
    localparam logic [BetaW-1:0] BetaReset = 14'd3435;
    localparam logic [T0W-1:0]   T0Reset   = 16'd29815;

    // natural log path, Q5.24 with headroom
    localparam int LgFracBits = 24;
    localparam int LnW        = 29;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;

    // inverse temperatures, unsigned Q.40
    localparam int InvT0W = 47;
    localparam int TermW  = 45;
    localparam int InvTW  = 49;
    localparam int DenW   = 48;

    // kelvin in thousandths, 22 quotient bits; more means saturated high
    localparam int TmW = 22;
    localparam logic [DenW-1:0] TmRemInit = 48'd262144000;
    localparam logic [22:0] KelvinOffsetMilli = 23'd273150;

    // reciprocal constants for the rounding divides by 100 and 500
    localparam logic [22:0] RecipC = 23'd5368710;
    localparam int RecipCShift = 29;
    localparam logic [25:0] RecipF = 26'd34359739;
    localparam int RecipFShift = 34;

    // output limits
    localparam int CMin = -2732;
    localparam int CMax = 16383;
    localparam int FMin = -4598;
    localparam int FMax = 29809;

    // status codes
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StZero = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StSat  = 2'd3;

    // flags that travel with an item
    typedef struct packed {
        logic zero;
        logic full;
        logic sat;
    } item_flags_t;

    // one result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_f;
        logic [14:0] temp_c;
    } result_t;

endpackage

`default_nettype wire

// ===== src/ntc_ln_pipe.sv =====
// ----------------------------------------------------------------------------
// ntc_ln_pipe
// Two-lane pipelined natural log in Q5.24: normalize, one squaring per stage
// for each fraction bit of log2, then scale by ln 2.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_ln_pipe
    import ntc_pkg::*;
#(
    parameter int NW     = 13,
    parameter int SIDE_W = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NW-1:0]     in_n_a,
    input  wire logic [NW-1:0]     in_n_b,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [LnW-1:0]         out_ln_a,
    output logic [LnW-1:0]         out_ln_b,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int EW  = $clog2(NW);
    localparam int NSQ = LgFracBits;

    logic [31:0]       m_reg     [2][NSQ+1];
    logic [LnW-1:0]    lg_reg    [2][NSQ+1];
    logic [LnW-1:0]    ln_reg    [2];
    logic              valid_reg [NSQ+2];
    logic [SIDE_W-1:0] side_reg  [NSQ+2];

    logic [NW-1:0]  n_in    [2];
    logic [31:0]    m0_next [2];
    logic [LnW-1:0] lg0_next[2];
    logic [LnW-1:0] ln_next [2];

    // normalize: exponent from the leading one, mantissa to Q1.31
    always_comb begin
        logic [EW-1:0] e;
        n_in[0] = in_n_a;
        n_in[1] = in_n_b;
        for (int l = 0; l < 2; l++) begin
            e = '0;
            for (int i = 0; i < NW; i++) begin
                if (n_in[l][i]) begin
                    e = EW'(i);
                end
            end
            m0_next[l]  = 32'(n_in[l]) << (6'd31 - 6'(e));
            lg0_next[l] = LnW'(e) << LgFracBits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int l = 0; l < 2; l++) begin
                m_reg[l][0]  <= m0_next[l];
                lg_reg[l][0] <= lg0_next[l];
            end
        end
    end

    // one squaring per stage, one log2 fraction bit each
    for (genvar j = 1; j <= NSQ; j++) begin : g_sq
        logic [31:0]    m_next  [2];
        logic [LnW-1:0] lg_next [2];

        always_comb begin
            logic [63:0] p;
            logic [32:0] s;
            for (int l = 0; l < 2; l++) begin
                p = 64'(m_reg[l][j-1]) * 64'(m_reg[l][j-1]);
                s = p[63:31];
                if (s[32]) begin
                    m_next[l]  = s[32:1];
                    lg_next[l] = lg_reg[l][j-1] | (LnW'(1) << (NSQ - j));
                end else begin
                    m_next[l]  = s[31:0];
                    lg_next[l] = lg_reg[l][j-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= side_reg[j-1];
                for (int l = 0; l < 2; l++) begin
                    m_reg[l][j]  <= m_next[l];
                    lg_reg[l][j] <= lg_next[l];
                end
            end
        end
    end

    // log2 times ln 2, rounded
    always_comb begin
        logic [60:0] prod;
        for (int l = 0; l < 2; l++) begin
            prod       = 61'(lg_reg[l][NSQ]) * 61'(Ln2Q32);
            ln_next[l] = LnW'((prod + (61'(1) << 31)) >> 32);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[NSQ+1] <= 1'b0;
        end else if (en) begin
            valid_reg[NSQ+1] <= valid_reg[NSQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[NSQ+1] <= side_reg[NSQ];
            ln_reg[0]       <= ln_next[0];
            ln_reg[1]       <= ln_next[1];
        end
    end

    assign out_valid = valid_reg[NSQ+1];
    assign out_ln_a  = ln_reg[0];
    assign out_ln_b  = ln_reg[1];
    assign out_side  = side_reg[NSQ+1];

endmodule

`default_nettype wire

// ===== src/ntc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ntc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a starting
// remainder so that high numerator bits can be folded in up front.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_div_pipe #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [DEN_W-1:0]  in_rem,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    // numerator bits shift out at the top while quotient bits shift in
    logic [NUM_W-1:0]  nq_reg    [NUM_W];
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];
    logic              valid_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_st
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              v_in;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [NUM_W-1:0]  nq_next;
        logic [DEN_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign nq_in   = in_num;
            assign rem_in  = in_rem;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign nq_in   = nq_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        // trial subtract
        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign nq_next  = {nq_in[NUM_W-2:0], ge};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]   <= nq_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== src/ntc_t0_recip.sv =====
// ----------------------------------------------------------------------------
// ntc_t0_recip
// Iterative divider for the inverse reference temperature in Q.40,
// one quotient bit per cycle, restarted on every reference update.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_t0_recip
    import ntc_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [T0W-1:0] t0,
    output logic                busy,
    output logic [InvT0W-1:0]   inv_t0
);

    localparam logic [InvT0W-1:0] InvT0Base = InvT0W'(100) << 40;
    localparam int CntW = $clog2(InvT0W + 1);

    logic [CntW-1:0]   count_reg, count_next;
    logic [InvT0W-1:0] nq_reg, nq_next;
    logic [T0W-1:0]    rem_reg, rem_next;
    logic [T0W-1:0]    den;
    logic [T0W:0]      trial;
    logic              ge;

    // a zero reference acts as one
    assign den   = (t0 == '0) ? T0W'(1) : t0;
    assign trial = {rem_reg, nq_reg[InvT0W-1]};
    assign ge    = trial >= {1'b0, den};

    // load, then one bit per cycle
    always_comb begin
        count_next = count_reg;
        nq_next    = nq_reg;
        rem_next   = rem_reg;
        if (start) begin
            count_next = CntW'(InvT0W);
            nq_next    = InvT0Base + InvT0W'(den >> 1);
            rem_next   = '0;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            nq_next    = {nq_reg[InvT0W-2:0], ge};
            rem_next   = ge ? T0W'(trial - {1'b0, den}) : trial[T0W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
    end

    assign busy   = count_reg != '0;
    assign inv_t0 = nq_reg;

endmodule

`default_nettype wire

// ===== src/thermistor_adc_to_temperature_core.sv =====
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// NTC thermistor converter: ADC code to tenths of degC and degF, beta equation.
// ----------------------------------------------------------------------------
// One sample beat per clock while s_tready is high; the pipeline depth
// is set by the 26-stage two-lane log pipeline (one squaring per log2 bit), the
// 45-stage divide by beta and the 22-stage divide for kelvin, each giving one
// quotient bit per stage. After reset and after each write of the reference
// temperature, s_tready stays low while an iterative divider
// forms the inverse reference temperature, one bit per cycle. Status on
// m_tuser: 0 ok, 1 code zero, 2 code at full scale, 3 saturated.
`default_nettype none

module thermistor_adc_to_temperature_core
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = AdcBitsDef
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // adc_code
    input  wire logic [((ADC_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // temp_c_tenths [14:0], temp_f_tenths [30:15], zero pad [31]
    output logic [31:0]                            m_tdata,
    // status
    output logic [1:0]                             m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [CfgAddrW-1:0]               cfg_addr,
    input  wire logic [CfgDataW-1:0]               cfg_wdata
);

    localparam int NW = ADC_BITS + 1;
    localparam logic [NW-1:0] FullScale = NW'(1) << ADC_BITS;

    // configuration registers
    logic [BetaW-1:0] beta_reg;
    logic [T0W-1:0]   t0_reg;
    logic             start_reg;
    logic [BetaW-1:0] beta_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg  <= BetaReset;
            t0_reg    <= T0Reset;
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_we && (cfg_addr == RegT0);
            if (cfg_we) begin
                case (cfg_addr)
                    RegBeta: beta_reg <= cfg_wdata[BetaW-1:0];
                    RegT0:   t0_reg   <= cfg_wdata[T0W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign beta_eff = (beta_reg == '0) ? BetaW'(1) : beta_reg;

    // inverse reference temperature
    logic              t0_busy;
    logic [InvT0W-1:0] inv_t0;

    ntc_t0_recip u_t0_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .t0      (t0_reg),
        .busy    (t0_busy),
        .inv_t0  (inv_t0)
    );

    // pipeline advance and input handshake
    logic    en;
    logic    skid_valid_reg;
    logic    s_acc;
    logic [ADC_BITS-1:0] code;

    assign en       = !skid_valid_reg;
    assign s_tready = en && !start_reg && !t0_busy;
    assign s_acc    = s_tvalid && s_tready;
    assign code     = s_tdata[ADC_BITS-1:0];

    // input stage: flags and the two log arguments
    logic          s0_valid_reg;
    logic [NW-1:0] s0_hi_reg, s0_lo_reg;
    item_flags_t   s0_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_hi_reg          <= FullScale - NW'(code);
            s0_lo_reg          <= (code == '0) ? NW'(1) : NW'(code);
            s0_flags_reg.zero  <= code == '0;
            s0_flags_reg.full  <= &code;
            s0_flags_reg.sat   <= 1'b0;
        end
    end

    // ln of both arguments
    logic           ln_valid;
    logic [LnW-1:0] ln_a, ln_b;
    logic [1:0]     ln_side;

    ntc_ln_pipe #(
        .NW     (NW),
        .SIDE_W (2)
    ) u_ln (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_n_a    (s0_hi_reg),
        .in_n_b    (s0_lo_reg),
        .in_side   ({s0_flags_reg.zero, s0_flags_reg.full}),
        .out_valid (ln_valid),
        .out_ln_a  (ln_a),
        .out_ln_b  (ln_b),
        .out_side  (ln_side)
    );

    // log ratio magnitude, scaled and biased for a rounded divide by beta
    logic             d_valid_reg;
    logic [TermW-1:0] d_num_reg;
    logic [2:0]       d_side_reg;
    logic signed [LnW:0] ratio_ln;
    logic [LnW:0]        ratio_abs;

    assign ratio_ln  = $signed({1'b0, ln_a}) - $signed({1'b0, ln_b});
    assign ratio_abs = ratio_ln[LnW] ? (LnW+1)'(-ratio_ln) : ratio_ln;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= ln_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_num_reg  <= (TermW'(ratio_abs) << 16) + TermW'(beta_eff >> 1);
            d_side_reg <= {ln_side, ratio_ln[LnW]};
        end
    end

    logic             term_valid;
    logic [TermW-1:0] term;
    logic [2:0]       term_side;

    ntc_div_pipe #(
        .NUM_W  (TermW),
        .DEN_W  (BetaW),
        .SIDE_W (3)
    ) u_div_beta (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_num    (d_num_reg),
        .in_den    (beta_eff),
        .in_rem    ('0),
        .in_side   (d_side_reg),
        .out_valid (term_valid),
        .out_quo   (term),
        .out_side  (term_side)
    );

    // inverse temperature and its range check
    logic              e_valid_reg;
    logic [DenW-1:0]   e_den_reg;
    item_flags_t       e_flags_reg;
    logic signed [InvTW-1:0] inv_t;
    logic              inv_t_sat;

    assign inv_t = term_side[0]
        ? $signed({2'b0, inv_t0}) - $signed({4'b0, term})
        : $signed({2'b0, inv_t0}) + $signed({4'b0, term});
    // nonpositive, or so small that kelvin overflows the quotient
    assign inv_t_sat = inv_t[InvTW-1] || (inv_t[DenW-1:0] <= TmRemInit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= term_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_den_reg        <= inv_t[DenW-1:0];
            e_flags_reg.zero <= term_side[2];
            e_flags_reg.full <= term_side[1];
            e_flags_reg.sat  <= inv_t_sat;
        end
    end

    logic           tm_valid;
    logic [TmW-1:0] tm;
    item_flags_t    tm_flags;

    ntc_div_pipe #(
        .NUM_W  (TmW),
        .DEN_W  (DenW),
        .SIDE_W (3)
    ) u_div_kelvin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_num    ('0),
        .in_den    (e_den_reg),
        .in_rem    (TmRemInit),
        .in_side   (e_flags_reg),
        .out_valid (tm_valid),
        .out_quo   (tm),
        .out_side  (tm_flags)
    );

    // celsius in thousandths, biased magnitudes for rounding
    logic              f_valid_reg;
    logic [22:0]       f_a_reg;
    logic [25:0]       f_b_reg;
    logic              f_neg_reg;
    item_flags_t       f_flags_reg;
    logic signed [22:0] cm;
    logic [21:0]       cm_abs;

    assign cm     = $signed({1'b0, tm}) - $signed(KelvinOffsetMilli);
    assign cm_abs = cm[22] ? 22'(-cm) : cm[21:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= tm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_a_reg     <= 23'(cm_abs) + 23'd50;
            f_b_reg     <= (26'(cm_abs) << 3) + 26'(cm_abs) + 26'd250;
            f_neg_reg   <= cm[22];
            f_flags_reg <= tm_flags;
        end
    end

    // divide by 100 and 500 through reciprocal multiplies
    logic        g_valid_reg;
    logic [16:0] g_qc_reg;
    logic [17:0] g_qf_reg;
    logic        g_neg_reg;
    item_flags_t g_flags_reg;
    logic [45:0] prod_c;
    logic [51:0] prod_f;

    assign prod_c = 46'(f_a_reg) * 46'(RecipC);
    assign prod_f = 52'(f_b_reg) * 52'(RecipF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_qc_reg    <= 17'(prod_c >> RecipCShift);
            g_qf_reg    <= 18'(prod_f >> RecipFShift);
            g_neg_reg   <= f_neg_reg;
            g_flags_reg <= f_flags_reg;
        end
    end

    // sign, offset, clamp and status
    logic signed [17:0] c_full;
    logic signed [19:0] f_full;
    result_t            res;

    assign c_full = g_neg_reg ? -$signed({1'b0, g_qc_reg}) : $signed({1'b0, g_qc_reg});
    assign f_full = (g_neg_reg ? -$signed({2'b0, g_qf_reg}) : $signed({2'b0, g_qf_reg}))
                    + 20'sd320;

    always_comb begin
        res.status = StOk;
        res.temp_c = '0;
        res.temp_f = '0;
        if (g_flags_reg.zero) begin
            res.status = StZero;
        end else if (g_flags_reg.full) begin
            res.status = StFull;
        end else if (g_flags_reg.sat) begin
            res.status = StSat;
            res.temp_c = 15'(CMax);
            res.temp_f = 16'(FMax);
        end else begin
            res.temp_c = c_full[14:0];
            res.temp_f = f_full[15:0];
            if (c_full > $signed(18'(CMax))) begin
                res.temp_c = 15'(CMax);
                res.status = StSat;
            end else if (c_full < $signed(18'(CMin))) begin
                res.temp_c = 15'(CMin);
                res.status = StSat;
            end
            if (f_full > $signed(20'(FMax))) begin
                res.temp_f = 16'(FMax);
                res.status = StSat;
            end else if (f_full < $signed(20'(FMin))) begin
                res.temp_f = 16'(FMin);
                res.status = StSat;
            end
        end
    end

    // output register with a skid slot behind it
    logic    out_valid_reg;
    result_t out_reg, skid_reg;
    logic    out_take;

    assign out_take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (g_valid_reg) begin
            if (!out_valid_reg || out_take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_reg <= skid_reg;
            end
        end else if (g_valid_reg) begin
            if (!out_valid_reg || out_take) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.temp_f, out_reg.temp_c};
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire
